[rtl/cospoly_pkg.sv]
`default_nettype none
package cospoly_pkg;

    localparam int ANGLE_FRAC_BITS  = 24;
    localparam int RESULT_FRAC_BITS = 30;

    // 2^34 / (2*pi), rounded to nearest.
    localparam logic [31:0] KTURN      = 32'd2734261102;
    localparam int          KTURN_FRAC = 34;
    localparam int          TURN_LSB   = ANGLE_FRAC_BITS + KTURN_FRAC - 32;

    // Horner cells; both polynomials are padded to this many steps with leading zeros.
    localparam int N_CELLS = 7;
    localparam int TERM_W  = $clog2(N_CELLS);

    localparam int ACC_W   = 33;
    localparam int PROD_W  = 66;
    localparam int SIN_SH  = 61 - RESULT_FRAC_BITS;
    localparam int COS_SH  = 31 - RESULT_FRAC_BITS;

    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;

    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic [31:0] y;
        logic [31:0] z;
        t_acc        acc;
        logic        sine;
        logic        neg;
    } t_stage;

    // Q1.31 coefficients, index 0 is the constant term.
    function automatic t_acc coef(input logic [TERM_W-1:0] term, input logic sine);
        t_acc c;
        c = '0;
        if (sine) begin
            case (term)
                3'd0:    c = 33'sd1124419809;
                3'd1:    c = -33'sd51377679;
                3'd2:    c = 33'sd704274;
                3'd3:    c = -33'sd4597;
                3'd4:    c = 33'sd18;
                default: c = '0;
            endcase
        end else begin
            case (term)
                3'd0:    c = 33'sd2147483647;
                3'd1:    c = -33'sd662337939;
                3'd2:    c = 33'sd34046945;
                3'd3:    c = -33'sd700062;
                3'd4:    c = 33'sd7711;
                3'd5:    c = -33'sd53;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/cospoly_in_if.sv]
`default_nettype none
interface cospoly_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface
`default_nettype wire

[rtl/cospoly_out_if.sv]
`default_nettype none
interface cospoly_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cosine;

    modport source (output valid, output cosine, input ready);
    modport sink   (input valid, input cosine, output ready);
endinterface
`default_nettype wire

[rtl/cospoly_reduce.sv]
`default_nettype none
module cospoly_reduce (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic signed [31:0]   i_angle,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output cospoly_pkg::t_stage       o_data
);
    import cospoly_pkg::*;

    // Four stages: angle, turn, folded y, squared y.
    logic [3:0] r_vld;
    logic [4:0] w_rdy;

    logic signed [31:0] r_angle;
    logic [31:0]        r_turn, n_turn;
    logic [31:0]        r_y, n_y;
    logic               r_sine, n_sine, r_neg, n_neg;
    t_stage             r_out, n_out;

    logic signed [64:0] w_turn_prod;
    logic [31:0]        w_t;
    logic [63:0]        w_yy;

    always_comb begin
        w_rdy[4] = i_ready;
        for (int i = 3; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[3];
    assign o_data  = r_out;

    // Angle times 1/(2*pi); the product wraps, keeping only the fractional turn.
    assign w_turn_prod = r_angle * $signed({1'b0, KTURN});
    assign n_turn      = w_turn_prod[TURN_LSB +: 32];

    always_comb begin
        w_t   = r_turn;
        n_neg = 1'b0;
        if (w_t > HALF_TURN) begin
            n_neg = 1'b1;
            w_t   = w_t - HALF_TURN;
        end
        if (w_t > QUARTER_TURN) begin
            n_neg = !n_neg;
            w_t   = HALF_TURN - w_t;
        end
        n_sine = (w_t > EIGHTH_TURN);
        if (n_sine) begin
            n_y = 32'((34'd3 << 30) - (34'd3 * {2'b00, w_t}));
        end else begin
            n_y = {w_t[30:0], 1'b0};
        end
    end

    always_comb begin
        w_yy       = {32'd0, r_y} * {32'd0, r_y};
        n_out.y    = r_y;
        n_out.z    = 32'((w_yy + (64'd1 << 29)) >> 30);
        n_out.acc  = '0;
        n_out.sine = r_sine;
        n_out.neg  = r_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < 4; i++) begin
                if (w_rdy[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_angle <= i_angle;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_turn <= n_turn;
        end
        if (w_rdy[2] && r_vld[1]) begin
            r_y    <= n_y;
            r_sine <= n_sine;
            r_neg  <= n_neg;
        end
        if (w_rdy[3] && r_vld[2]) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

[rtl/cospoly_cell.sv]
`default_nettype none
module cospoly_cell (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [cospoly_pkg::TERM_W-1:0]    i_term,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire cospoly_pkg::t_stage               i_data,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output cospoly_pkg::t_stage                    o_data
);
    import cospoly_pkg::*;

    // One Horner step: acc = c[term] + round(acc * z / 2^30).
    logic   r_vld;
    t_stage r_data, n_data;
    t_prod  w_prod, w_rnd;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_comb begin
        w_prod     = i_data.acc * $signed({1'b0, i_data.z});
        w_rnd      = (w_prod + (t_prod'(1) <<< 29)) >>> 30;
        n_data     = i_data;
        n_data.acc = coef(i_term, i_data.sine) + ACC_W'(w_rnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule
`default_nettype wire

[rtl/cospoly_finish.sv]
`default_nettype none
module cospoly_finish (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire cospoly_pkg::t_stage  i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic signed [31:0]        o_cosine
);
    import cospoly_pkg::*;

    localparam t_prod LIM = t_prod'(1) <<< RESULT_FRAC_BITS;

    logic [1:0]         r_vld;
    logic [2:0]         w_rdy;
    t_prod              r_prod, n_prod;
    logic               r_sine, r_neg;
    logic signed [31:0] r_cosine, n_cosine;
    t_prod              w_res;

    always_comb begin
        w_rdy[2] = i_ready;
        for (int i = 1; i >= 0; i--) begin
            w_rdy[i] = !r_vld[i] || w_rdy[i+1];
        end
    end

    assign o_ready  = w_rdy[0];
    assign o_valid  = r_vld[1];
    assign o_cosine = r_cosine;

    // The sine branch scales the polynomial by y; the cosine branch passes it through.
    always_comb begin
        if (i_data.sine) begin
            n_prod = $signed({1'b0, i_data.y}) * i_data.acc;
        end else begin
            n_prod = PROD_W'(i_data.acc);
        end
    end

    always_comb begin
        if (r_sine) begin
            w_res = (r_prod + (t_prod'(1) <<< (SIN_SH - 1))) >>> SIN_SH;
        end else begin
            w_res = (r_prod + (t_prod'(1) <<< (COS_SH - 1))) >>> COS_SH;
        end
        if (w_res > LIM) begin
            w_res = LIM;
        end
        if (w_res < -LIM) begin
            w_res = -LIM;
        end
        if (r_neg) begin
            w_res = -w_res;
        end
        n_cosine = 32'(w_res);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_prod <= n_prod;
            r_sine <= i_data.sine;
            r_neg  <= i_data.neg;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_cosine <= n_cosine;
        end
    end

    // The result never exceeds one in magnitude.
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_cosine <= 32'sd1 <<< RESULT_FRAC_BITS)
                  && (r_cosine >= -(32'sd1 <<< RESULT_FRAC_BITS)))
        else $error("cosine result out of range");

    // Over the folded range both polynomials, and their product with y, stay positive.
    a_prod_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> !r_prod[PROD_W-1])
        else $error("negative magnitude before sign fold");

    // Reset leaves both stages empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (r_vld == 2'b00))
        else $error("stage valid after reset");

endmodule
`default_nettype wire

[rtl/cosine_polynomial_unit_top.sv]
// An accepted input transaction passes the front end, the Horner cells and the finishing block.
// Throughput: one transaction per cycle without backpressure; every stage holds one item.
// Backpressure stalls only the stages that are full; bubbles are squeezed out upstream.
// Reset (i_rst_n low, synchronous) empties the pipeline; the data registers are not reset.
`default_nettype none
module cosine_polynomial_unit_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    cospoly_in_if.sink   i_in,
    cospoly_out_if.source o_out
);
    import cospoly_pkg::*;

    // The front end converts the angle to a fractional turn, folds it into the
    // first eighth-turn (remembering the sign of the reflections), selects the
    // sine or cosine polynomial, and squares y. It takes four stages.
    //
    // A row of identical Horner cells follows. Each cell adds one coefficient
    // and multiplies by z, handing the running sum to its neighbor. Both
    // polynomials run through all seven cells: each is padded with zero top
    // coefficients (two for sine, one for cosine), which leave its value unchanged.
    //
    // The finishing block applies the final scaling by y on the sine branch,
    // rounds to the output format, clamps and applies the sign, in two stages.

    t_stage w_data [N_CELLS+1];
    logic   w_vld  [N_CELLS+1];
    logic   w_rdy  [N_CELLS+1];

    cospoly_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_angle (i_in.angle),
        .o_valid (w_vld[0]),
        .i_ready (w_rdy[0]),
        .o_data  (w_data[0])
    );

    // Cell g evaluates the term of order N_CELLS-1-g, so the constant term comes last.
    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        cospoly_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_term  (TERM_W'(N_CELLS - 1 - g)),
            .i_valid (w_vld[g]),
            .o_ready (w_rdy[g]),
            .i_data  (w_data[g]),
            .o_valid (w_vld[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    cospoly_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_vld[N_CELLS]),
        .o_ready  (w_rdy[N_CELLS]),
        .i_data   (w_data[N_CELLS]),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_cosine (o_out.cosine)
    );

endmodule
`default_nettype wire
